FILE: design/rfd_pkg.sv
`timescale 1ns / 1ps

package rfd_pkg;

    localparam int STREAM_DEPTH = 64;
    localparam int FRAME_MAX    = 64;
    localparam int ADDR_W       = $clog2(STREAM_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int FL_W         = $clog2(FRAME_MAX + 1);
    localparam int LEN_W        = 16;
    localparam int PLEN_W       = 6;
    localparam int MIN_FRAME    = 7;
    localparam int HEAD_BYTES   = 3;
    localparam int OFS_ADDR     = 3;
    localparam int OFS_FUNC     = 4;
    localparam int OFS_PAYLOAD  = 5;

    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_TAIL   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HDR,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_TAIL,
        ST_SUM,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] tail_byte;
    } cfg_t;

    // Circular index: base plus an offset of at most the depth.
    function automatic logic [ADDR_W-1:0] wrap_idx(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = {2'b00, base} + {1'b0, off};
        if (s >= (CNT_W + 1)'(STREAM_DEPTH))
        begin
            s = s - (CNT_W + 1)'(STREAM_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/rfd_ram.sv
`timescale 1ns / 1ps

module rfd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rfd_cfg.sv
`timescale 1ns / 1ps

module rfd_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rfd_pkg::cfg_t cfg
);
    import rfd_pkg::*;

    logic [7:0] header_reg;
    logic [7:0] tail_reg;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= 8'd104;
            tail_reg   <= 8'd22;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_HEADER: header_reg <= pwdata[7:0];
                REG_TAIL:   tail_reg   <= pwdata[7:0];
                default:    header_reg <= header_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HEADER: prdata = {24'd0, header_reg};
            REG_TAIL:   prdata = {24'd0, tail_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.header_byte = header_reg;
    assign cfg.tail_byte   = tail_reg;

endmodule

FILE: design/rfd_ctrl.sv
`timescale 1ns / 1ps

module rfd_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rfd_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               out_data,
    output logic                      out_present,
    output logic                      out_last,
    output logic                      ram_we,
    output logic [rfd_pkg::ADDR_W-1:0] ram_waddr,
    output logic [7:0]                ram_wdata,
    output logic [rfd_pkg::ADDR_W-1:0] ram_raddr,
    input  logic [7:0]                ram_rdata
);
    import rfd_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [FL_W-1:0]   flen_reg, flen_next;
    logic [FL_W-1:0]   off_reg, off_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        addr_reg, addr_next;
    logic [7:0]        func_reg, func_next;
    logic              ok_reg, ok_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic              op_reg, op_next;
    logic              ol_reg, ol_next;

    logic [LEN_W-1:0]  flen_rd;
    logic              len_bad;
    logic              len_short;
    logic              is_header;
    logic              tail_good;
    logic              accept_in;
    logic              accept_out;
    logic              plen_zero;
    logic              at_cks;
    logic              at_last;
    logic              full;
    logic [PLEN_W-1:0] plen;

    assign flen_rd    = {ram_rdata, len_lo_reg};
    assign len_bad    = (flen_rd < LEN_W'(MIN_FRAME)) || (flen_rd > LEN_W'(FRAME_MAX));
    assign len_short  = LEN_W'(count_reg) < flen_rd;
    assign is_header  = ram_rdata == cfg.header_byte;
    assign tail_good  = ram_rdata == cfg.tail_byte;
    assign in_ready   = state_reg == ST_IDLE;
    assign accept_in  = in_valid && in_ready;
    assign accept_out = ov_reg && out_ready;
    assign plen_zero  = flen_reg == FL_W'(MIN_FRAME);
    assign at_cks     = off_reg == flen_reg - FL_W'(2);
    assign at_last    = plen_zero || (off_reg == flen_reg - FL_W'(3));
    assign full       = count_reg == CNT_W'(STREAM_DEPTH);
    assign plen       = PLEN_W'(flen_reg - FL_W'(MIN_FRAME));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept_in) state_next = ST_SCAN;
            ST_SCAN:      state_next = (count_reg == '0) ? ST_IDLE : ST_HDR;
            ST_HDR:
            begin
                if (!is_header)
                begin
                    state_next = ST_SCAN;
                end
                else if (count_reg < CNT_W'(HEAD_BYTES))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:    state_next = ST_LEN_HI;
            ST_LEN_HI:
            begin
                if (len_bad)
                begin
                    state_next = ST_SCAN;
                end
                else if (len_short)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:      state_next = tail_good ? ST_SUM : ST_SCAN;
            ST_SUM:       if (at_cks) state_next = ST_EMIT_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (accept_out)
                begin
                    state_next = ol_reg ? ST_SCAN : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        start_next  = start_reg;
        count_next  = count_reg;
        len_lo_next = len_lo_reg;
        flen_next   = flen_reg;
        off_next    = off_reg;
        sum_next    = sum_reg;
        addr_next   = addr_reg;
        func_next   = func_reg;
        ok_next     = ok_reg;
        ov_next     = ov_reg;
        ob_next     = ob_reg;
        op_next     = op_reg;
        ol_next     = ol_reg;
        ram_we      = 1'b0;
        ram_waddr   = full ? start_reg : wrap_idx(start_reg, count_reg);
        ram_wdata   = in_byte;
        ram_raddr   = start_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    ram_we = 1'b1;
                    if (full)
                    begin
                        start_next = wrap_idx(start_reg, CNT_W'(1));
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr = start_reg;
            end
            ST_HDR:
            begin
                ram_raddr = wrap_idx(start_reg, CNT_W'(1));
                if (!is_header)
                begin
                    start_next = wrap_idx(start_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_LEN_LO:
            begin
                len_lo_next = ram_rdata;
                ram_raddr   = wrap_idx(start_reg, CNT_W'(2));
            end
            ST_LEN_HI:
            begin
                flen_next = FL_W'(flen_rd);
                ram_raddr = wrap_idx(start_reg, CNT_W'(flen_rd - LEN_W'(1)));
                if (len_bad)
                begin
                    start_next = wrap_idx(start_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_TAIL:
            begin
                ram_raddr = wrap_idx(start_reg, CNT_W'(OFS_ADDR));
                off_next  = FL_W'(OFS_ADDR);
                sum_next  = 8'd0;
                if (!tail_good)
                begin
                    start_next = wrap_idx(start_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_SUM:
            begin
                ram_raddr = wrap_idx(start_reg, CNT_W'(off_reg + FL_W'(1)));
                off_next  = off_reg + FL_W'(1);
                if (off_reg == FL_W'(OFS_ADDR))
                begin
                    addr_next = ram_rdata;
                end
                if (off_reg == FL_W'(OFS_FUNC))
                begin
                    func_next = ram_rdata;
                end
                if (at_cks)
                begin
                    ok_next  = sum_reg == ram_rdata;
                    off_next = FL_W'(OFS_PAYLOAD);
                end
                else
                begin
                    sum_next = sum_reg + ram_rdata;
                end
            end
            ST_EMIT_RD:
            begin
                ram_raddr = wrap_idx(start_reg, CNT_W'(off_reg));
            end
            ST_EMIT_LD:
            begin
                ov_next = 1'b1;
                ob_next = plen_zero ? 8'd0 : ram_rdata;
                op_next = !plen_zero;
                ol_next = at_last;
            end
            ST_EMIT_WAIT:
            begin
                if (accept_out)
                begin
                    ov_next  = 1'b0;
                    off_next = off_reg + FL_W'(1);
                    if (ol_reg)
                    begin
                        start_next = wrap_idx(start_reg, CNT_W'(flen_reg));
                        count_next = count_reg - CNT_W'(flen_reg);
                    end
                end
            end
            default:
            begin
                ov_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_lo_reg <= len_lo_next;
        flen_reg   <= flen_next;
        off_reg    <= off_next;
        sum_reg    <= sum_next;
        addr_reg   <= addr_next;
        func_reg   <= func_next;
        ok_reg     <= ok_next;
        ob_reg     <= ob_next;
        op_reg     <= op_next;
        ol_reg     <= ol_next;
    end

    assign out_valid   = ov_reg;
    assign out_present = op_reg;
    assign out_last    = ol_reg;
    assign out_data    = {1'b0, ok_reg, plen, func_reg, addr_reg, ob_reg};

endmodule

FILE: design/resync_frame_deframer_top.sv
`timescale 1ns / 1ps

// Frame extractor for a byte stream from a serial receiver.
// Input channel s_axis: one received byte per transfer in s_axis_tdata[7:0].
// Bytes go into a 64-entry circular buffer; when it is full the oldest byte
// is dropped. Frames are header, 16-bit little-endian length, address,
// function, payload, checksum and tail.
// Output channel m_axis: one transfer per payload byte of each complete frame,
// or a single transfer with tuser low for a frame with no payload; tlast marks
// the final transfer of a frame. Every transfer repeats the address, function
// code, payload length and the checksum verdict.
// A byte is taken only while the block is idle. Each byte taken starts a scan
// that discards non-header bytes and rejected header candidates (bad length
// or bad tail) one byte at a time, and checks and emits each completed frame
// in turn; the block is idle again once it has to wait for more bytes.
// All of this runs through the one read port of the buffer memory.
// When the receiver stalls, the current output transfer is held and no new
// byte is taken. Reset empties the buffer and restores header 0x68 and tail
// 0x16; the header and tail bytes are APB registers at addresses 0 and 4.
module resync_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // payload_byte, address, function_code, payload_length, checksum_ok, zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tuser,   // byte_present
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rfd_pkg::*;

    cfg_t              cfg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    rfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfd_ram #(
        .DEPTH (STREAM_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_present (m_axis_tuser),
        .out_last    (m_axis_tlast),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

endmodule

FILE: test/resync_frame_deframer_top_tb.sv
`timescale 1ns / 1ps

module resync_frame_deframer_top_tb;
    import rfd_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE       = 3000;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_present;
        logic       last;
        logic [7:0] address;
        logic [7:0] function_code;
        logic [5:0] payload_length;
        logic       checksum_ok;
    } payload_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    resync_frame_deframer_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [7:0]    rx_bytes[$];
    payload_item_t expected_payload[$];

    logic [7:0] buf_mem[STREAM_DEPTH];
    int         buf_head;
    int         buf_fill;
    logic [7:0] hdr_val;
    logic [7:0] tail_val;

    int  errors;
    int  cycles;
    int  bytes_sent;
    int  frames_seen;
    int  results_seen;
    int  send_gap;
    int  hold_cnt;
    bit  pressure_done;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] peek_buf(int off);
        return buf_mem[(buf_head + off) % STREAM_DEPTH];
    endfunction

    function automatic void drop_buf(int n);
        if (n > buf_fill)
        begin
            n = buf_fill;
        end
        buf_head = (buf_head + n) % STREAM_DEPTH;
        buf_fill = buf_fill - n;
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        int            produced;
        int            flen;
        int            plen;
        int            nres;
        logic [7:0]    sum;
        payload_item_t it;
        produced = 0;
        if (buf_fill >= STREAM_DEPTH)
        begin
            drop_buf(1);
        end
        buf_mem[(buf_head + buf_fill) % STREAM_DEPTH] = b;
        buf_fill++;
        while (buf_fill > 0)
        begin
            while (buf_fill > 0 && peek_buf(0) != hdr_val)
            begin
                drop_buf(1);
            end
            if (buf_fill < HEAD_BYTES)
            begin
                break;
            end
            flen = int'(peek_buf(1)) | (int'(peek_buf(2)) << 8);
            if (flen < MIN_FRAME || flen > FRAME_MAX)
            begin
                drop_buf(1);
                continue;
            end
            if (buf_fill < flen)
            begin
                break;
            end
            if (peek_buf(flen - 1) != tail_val)
            begin
                drop_buf(1);
                continue;
            end
            plen = flen - MIN_FRAME;
            nres = (plen == 0) ? 1 : plen;
            if (produced + nres > 64)
            begin
                break;
            end
            sum = peek_buf(OFS_ADDR) + peek_buf(OFS_FUNC);
            for (int i = 0; i < plen; i++)
            begin
                sum = sum + peek_buf(OFS_PAYLOAD + i);
            end
            for (int k = 0; k < nres; k++)
            begin
                it.payload_byte   = (plen == 0) ? 8'h00 : peek_buf(OFS_PAYLOAD + k);
                it.byte_present   = (plen != 0);
                it.last           = (k + 1 == nres);
                it.address        = peek_buf(OFS_ADDR);
                it.function_code  = peek_buf(OFS_FUNC);
                it.payload_length = plen[5:0];
                it.checksum_ok    = (sum == peek_buf(flen - 2));
                expected_payload.push_back(it);
                produced++;
            end
            frames_seen++;
            drop_buf(flen);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 20);
    endfunction

    // Sender side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata);
                bytes_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the offered byte
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (rx_bytes.size() > 0)
            begin
                s_axis_tdata  <= rx_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side: random stalls plus one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt = 0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else if (!pressure_done && bytes_sent > 220)
        begin
            pressure_done = 1'b1;
            hold_cnt = 4000;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(99) < 5)
            begin
                hold_cnt = $urandom_range(40, 10);
            end
            m_axis_tready <= ($urandom_range(99) < 70);
        end
    end

    always @(posedge clk)
    begin
        payload_item_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_payload.size() == 0)
            begin
                $error("unexpected output transfer tdata=%h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expected_payload.pop_front();
                if (m_axis_tdata[7:0] !== e.payload_byte)
                begin
                    $error("payload_byte expected %h actual %h", e.payload_byte,
                           m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tuser !== e.byte_present)
                begin
                    $error("byte_present expected %b actual %b", e.byte_present, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last expected %b actual %b", e.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== e.address)
                begin
                    $error("address expected %h actual %h", e.address, m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== e.function_code)
                begin
                    $error("function_code expected %h actual %h", e.function_code,
                           m_axis_tdata[23:16]);
                    errors++;
                end
                if (m_axis_tdata[29:24] !== e.payload_length)
                begin
                    $error("payload_length expected %0d actual %0d", e.payload_length,
                           m_axis_tdata[29:24]);
                    errors++;
                end
                if (m_axis_tdata[30] !== e.checksum_ok)
                begin
                    $error("checksum_ok expected %b actual %b", e.checksum_ok, m_axis_tdata[30]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("resync_frame_deframer_top verification failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd0)
        begin
            hdr_val = val;
        end
        else
        begin
            tail_val = val;
        end
    endtask

    task automatic push_frame(input int plen, input bit bad_sum, input bit bad_tail,
                              input bit extreme);
        logic [7:0] a;
        logic [7:0] f;
        logic [7:0] p;
        logic [7:0] sum;
        a = extreme ? 8'hFF : 8'($urandom);
        f = extreme ? 8'h00 : 8'($urandom);
        rx_bytes.push_back(hdr_val);
        rx_bytes.push_back(8'(plen + MIN_FRAME));
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(a);
        rx_bytes.push_back(f);
        sum = a + f;
        for (int i = 0; i < plen; i++)
        begin
            p = 8'($urandom);
            sum = sum + p;
            rx_bytes.push_back(p);
        end
        rx_bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
        rx_bytes.push_back(bad_tail ? tail_val ^ 8'($urandom_range(255, 1)) : tail_val);
    endtask

    task automatic run_phase();
        while (rx_bytes.size() > 0 || s_axis_tvalid || expected_payload.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_traffic(input int n_items);
        int r;
        int target;
        target = rx_bytes.size() + n_items;
        while (rx_bytes.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 68)
            begin
                if ($urandom_range(9) == 0)
                begin
                    push_frame($urandom_range(57, 20), $urandom_range(5) == 0, 1'b0, 1'b0);
                end
                else
                begin
                    push_frame($urandom_range(8), $urandom_range(5) == 0,
                               $urandom_range(9) == 0, 1'b0);
                end
            end
            else if (r < 83)
            begin
                repeat ($urandom_range(4, 1)) rx_bytes.push_back(8'($urandom));
            end
            else if (r < 93)
            begin
                rx_bytes.push_back(hdr_val);
                rx_bytes.push_back(8'($urandom));
                rx_bytes.push_back(8'($urandom));
            end
            else
            begin
                rx_bytes.push_back(hdr_val);
                rx_bytes.push_back(8'($urandom_range(20, 7)));
                rx_bytes.push_back(8'h00);
                repeat ($urandom_range(3)) rx_bytes.push_back(8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'h0;
        errors        = 0;
        cycles        = 0;
        bytes_sent    = 0;
        frames_seen   = 0;
        results_seen  = 0;
        pressure_done = 1'b0;
        buf_head      = 0;
        buf_fill      = 0;
        hdr_val       = 8'd104;
        tail_val      = 8'd22;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset values of the registers.
        push_frame(0, 1'b0, 1'b0, 1'b1);
        push_frame(1, 1'b1, 1'b0, 1'b1);
        push_frame(1, 1'b0, 1'b1, 1'b0);
        rx_bytes.push_back(hdr_val);
        rx_bytes.push_back(8'd6);
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(hdr_val);
        rx_bytes.push_back(8'd65);
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(hdr_val);
        rx_bytes.push_back(8'hFF);
        rx_bytes.push_back(8'hFF);
        // An outer candidate holds two complete frames until its bad tail shows.
        rx_bytes.push_back(hdr_val);
        rx_bytes.push_back(8'd18);
        rx_bytes.push_back(8'h00);
        push_frame(0, 1'b0, 1'b0, 1'b0);
        push_frame(0, 1'b0, 1'b0, 1'b0);
        rx_bytes.push_back(tail_val ^ 8'h01);
        run_phase();

        apb_write(3'd0, 8'h68);
        apb_write(3'd4, 8'h16);
        push_frame(57, 1'b0, 1'b0, 1'b0);
        random_traffic(90);
        run_phase();

        apb_write(3'd0, 8'h00);
        apb_write(3'd4, 8'hFF);
        random_traffic(80);
        run_phase();

        apb_write(3'd0, 8'hFF);
        apb_write(3'd4, 8'h00);
        random_traffic(80);
        run_phase();

        apb_write(3'd0, 8'($urandom));
        apb_write(3'd4, 8'($urandom));
        push_frame(57, 1'b1, 1'b0, 1'b0);
        random_traffic(80);
        run_phase();

        $display("Sent %0d bytes over five register settings; %0d frames gave %0d transfers.",
                 bytes_sent, frames_seen, results_seen);
        if (errors == 0)
        begin
            $display("resync_frame_deframer_top verification clean");
        end
        else
        begin
            $display("resync_frame_deframer_top verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/rfd_pkg.sv
design/rfd_ram.sv
design/rfd_cfg.sv
design/rfd_ctrl.sv
design/resync_frame_deframer_top.sv
test/resync_frame_deframer_top_tb.sv
